// ===== rtl/hmtc_pkg.sv =====
// Shared constants and types for the Huffman path length block.
`default_nettype none
package hmtc_pkg;
  localparam int MAX_SYMBOLS = 64;
  localparam int ADDR_W      = $clog2(MAX_SYMBOLS);
  localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W       = ADDR_W + 2;
  localparam int HEAP_W      = 22;
  localparam int WEIGHT_W    = 16;
  localparam int COST_W      = 32;
  localparam int SCOUNT_W    = 7;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } hmtc_item_t;

  typedef struct packed {
    logic [COST_W-1:0]   total_cost;
    logic [SCOUNT_W-1:0] symbol_count;
  } hmtc_result_t;
endpackage
`default_nettype wire

// ===== rtl/huffman_min_total_cost.sv =====
// Top level of the Huffman minimum weighted path length block.
`default_nettype none
// Stream in symbol weights, one per transfer; in_tlast marks the final weight
// of a set. Up to 64 weights are kept (a weight beyond that is dropped, but a
// tlast on it still closes the set). Each weight is queued, then inserted into
// a min-heap memory with a single read port by a sift-up walk, a read state
// and a compare state per level. After the last weight the engine repeatedly
// removes two minima (each by a sift-down walk that reads the children of a
// level, compares and moves down), adds them, adds the sum to the cost and
// inserts it again by a sift-up walk, with a check state before each merge,
// until one entry is left. One result transfer follows per set: total cost
// (sum of all merge weights, 0 for a lone symbol) and the number of weights
// loaded. A four-deep input queue lets the next set start arriving while the
// current one merges, and the output register holds a result until it is
// taken.
module huffman_min_total_cost
  import hmtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] weight
  input  wire logic        in_tlast,   // last_weight
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] total_cost, [38:32] symbol_count
);
  hmtc_item_t   q_item;
  logic         q_valid, q_pop;
  hmtc_result_t res;
  logic         res_valid, res_ready;
  logic         out_valid_r;
  hmtc_result_t out_r;

  hmtc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_item, .q_pop
  );

  hmtc_heap u_heap (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .res_valid, .res, .res_ready
  );

  // Take a new result when the output register is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.symbol_count, out_r.total_cost};
endmodule
`default_nettype wire

// ===== rtl/hmtc_front.sv =====
// Input front end: accepts weight transfers into a short queue.
`default_nettype none
module hmtc_front
  import hmtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tlast,
  output logic             q_valid,
  output hmtc_item_t       q_item,
  input  wire logic        q_pop
);
  hmtc_item_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]   level_r, level_nxt;
  logic              push, pop;

  assign in_tready = (level_r != (QPTR_W+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (level_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = slot_r[rd_r];

  always_comb begin
    wr_nxt    = push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
    level_nxt = level_r;
    if (push && !pop) level_nxt = level_r + 1'b1;
    else if (pop && !push) level_nxt = level_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r].weight <= in_tdata[WEIGHT_W-1:0];
      slot_r[wr_r].last   <= in_tlast;
    end
  end

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= (QPTR_W+1)'(QDEPTH)) else $error("queue level over depth");
`endif
endmodule
`default_nettype wire

// ===== rtl/hmtc_heap.sv =====
// Heap engine: loads weights into a min-heap and merges down to one entry.
`default_nettype none
module hmtc_heap
  import hmtc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  wire hmtc_item_t q_item,
  output logic        q_pop,
  output logic        res_valid,
  output hmtc_result_t res,
  input  wire logic   res_ready
);
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UP_RD  = 4'd1;
  localparam logic [3:0] ST_UP_CMP = 4'd2;
  localparam logic [3:0] ST_CHK    = 4'd3;
  localparam logic [3:0] ST_TOP    = 4'd4;
  localparam logic [3:0] ST_LAST   = 4'd5;
  localparam logic [3:0] ST_DN_L   = 4'd6;
  localparam logic [3:0] ST_DN_R   = 4'd7;
  localparam logic [3:0] ST_DN_CMP = 4'd8;
  localparam logic [3:0] ST_DN_DEC = 4'd9;
  localparam logic [3:0] ST_TM_END = 4'd10;

  logic [HEAP_W-1:0] mem [MAX_SYMBOLS];
  logic [HEAP_W-1:0] rdata_r;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [HEAP_W-1:0] wdata;
  logic              we;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, loaded_r, loaded_nxt;
  logic [COST_W-1:0] acc_r, acc_nxt;
  logic              merge_r, merge_nxt, phase_r, phase_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt, cidx_r, cidx_nxt;
  logic [HEAP_W-1:0] item_r, item_nxt, cval_r, cval_nxt, a_r, a_nxt;
  logic [ADDR_W-1:0] pos_m1;
  logic [IDX_W-1:0]  l_ext, r_ext, n_ext;
  logic [CNT_W-1:0]  cnt_m1;
  logic [HEAP_W-1:0] merge_sum;
  // Hold the removed top across the sift-down walk.
  logic [HEAP_W-1:0] top_hold_r;

  function automatic logic [COST_W-1:0] sum_sat(input logic [COST_W-1:0] acc,
                                                 input logic [HEAP_W-1:0] s);
    logic [COST_W:0] t;
    t = {1'b0, acc} + (COST_W+1)'(s);
    sum_sat = t[COST_W] ? {COST_W{1'b1}} : t[COST_W-1:0];
  endfunction

  assign pos_m1    = pos_r - 1'b1;
  assign l_ext     = {1'b0, pos_r, 1'b1};
  assign r_ext     = l_ext + 1'b1;
  assign n_ext     = IDX_W'(cnt_r);
  assign cnt_m1    = cnt_r - 1'b1;
  assign merge_sum = a_r + top_hold_r;

  assign res_valid        = (state_r == ST_CHK) && (cnt_r <= CNT_W'(1));
  assign res.total_cost   = acc_r;
  assign res.symbol_count = SCOUNT_W'(loaded_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    loaded_nxt = loaded_r;
    acc_nxt    = acc_r;
    merge_nxt  = merge_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    cidx_nxt   = cidx_r;
    item_nxt   = item_r;
    cval_nxt   = cval_r;
    a_nxt      = a_r;
    raddr      = '0;
    waddr      = pos_r;
    wdata      = item_r;
    we         = 1'b0;
    q_pop      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          merge_nxt = q_item.last;
          if (cnt_r < CNT_W'(MAX_SYMBOLS)) begin
            item_nxt  = HEAP_W'(q_item.weight);
            pos_nxt   = cnt_r[ADDR_W-1:0];
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_UP_RD;
          end else if (q_item.last) begin
            state_nxt = ST_CHK;
          end
          if (q_item.last) begin
            loaded_nxt = (cnt_r < CNT_W'(MAX_SYMBOLS)) ? cnt_r + 1'b1 : cnt_r;
          end
        end
      end
      ST_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = merge_r ? ST_CHK : ST_IDLE;
        end else begin
          raddr     = {1'b0, pos_m1[ADDR_W-1:1]};
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (rdata_r > item_r) begin
          wdata     = rdata_r;
          pos_nxt   = {1'b0, pos_m1[ADDR_W-1:1]};
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = merge_r ? ST_CHK : ST_IDLE;
        end
      end
      ST_CHK: begin
        if (cnt_r <= CNT_W'(1)) begin
          if (res_ready) begin
            cnt_nxt   = '0;
            acc_nxt   = '0;
            merge_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end else begin
          phase_nxt = 1'b0;
          state_nxt = ST_TOP;
        end
      end
      ST_TOP: begin
        cnt_nxt = cnt_m1;
        if (cnt_m1 != '0) begin
          raddr     = cnt_m1[ADDR_W-1:0];
          state_nxt = ST_LAST;
        end else begin
          state_nxt = ST_TM_END;
        end
        // cval_r takes the top too, but the end step uses the copy in top_hold_r
        cval_nxt = rdata_r;
      end
      ST_LAST: begin
        item_nxt  = rdata_r;
        pos_nxt   = '0;
        state_nxt = ST_DN_L;
      end
      ST_DN_L: begin
        if (l_ext < n_ext) begin
          raddr     = l_ext[ADDR_W-1:0];
          state_nxt = ST_DN_R;
        end else begin
          we        = 1'b1;
          state_nxt = ST_TM_END;
        end
      end
      ST_DN_R: begin
        cval_nxt = rdata_r;
        cidx_nxt = l_ext[ADDR_W-1:0];
        if (r_ext < n_ext) begin
          raddr     = r_ext[ADDR_W-1:0];
          state_nxt = ST_DN_CMP;
        end else begin
          state_nxt = ST_DN_DEC;
        end
      end
      ST_DN_CMP: begin
        if (rdata_r < cval_r) begin
          cval_nxt = rdata_r;
          cidx_nxt = r_ext[ADDR_W-1:0];
        end
        state_nxt = ST_DN_DEC;
      end
      ST_DN_DEC: begin
        we = 1'b1;
        if (item_r <= cval_r) begin
          state_nxt = ST_TM_END;
        end else begin
          wdata     = cval_r;
          pos_nxt   = cidx_r;
          state_nxt = ST_DN_L;
        end
      end
      ST_TM_END: begin
        // a_r doubles as the saved top of this removal
        if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = ST_TOP;
        end else begin
          item_nxt  = merge_sum;
          acc_nxt   = sum_sat(acc_r, merge_sum);
          pos_nxt   = cnt_r[ADDR_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_UP_RD;
        end
        if (!phase_r) a_nxt = top_hold_r;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TOP) top_hold_r <= rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      acc_r    <= '0;
      merge_r  <= 1'b0;
      phase_r  <= 1'b0;
      loaded_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      merge_r  <= merge_nxt;
      phase_r  <= phase_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cidx_r <= cidx_nxt;
    item_r <= item_nxt;
    cval_r <= cval_nxt;
    a_r    <= a_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SYMBOLS)) else $error("heap count over capacity");
  a_res_one: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> merge_r) else $error("result outside a merge run");
  a_res_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (cnt_r == '0 && acc_r == '0))
    else $error("state not cleared after result");
`endif
endmodule
`default_nettype wire
